>>> design/cvmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_pkg
// Shared types and constants of the multi-filter valid-window convolution.
// ----------------------------------------------------------------------------
package cvmf_pkg;

	localparam int VALUE_W    = 16;
	localparam int WIDX_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int SUM_W      = 36;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 6;
	localparam int FIDX_W     = 3;
	localparam int ROWS_W     = 11;
	localparam int COLS_W     = 7;
	localparam int FCNT_W     = 4;
	localparam int KSIZE_W    = 3;
	localparam int MAX_ROWS   = 1024;

	localparam logic [ROWS_W-1:0]  ROWS_RESET  = 11'd28;
	localparam logic [COLS_W-1:0]  COLS_RESET  = 7'd28;
	localparam logic [FCNT_W-1:0]  FCNT_RESET  = 4'd8;
	localparam logic [KSIZE_W-1:0] KSIZE_RESET = 3'd3;

	typedef enum logic {
		OP_WEIGHT = 1'b0,
		OP_PIXEL  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_ROWS   = 3'd0,
		REG_IMAGE_COLS   = 3'd1,
		REG_FILTER_COUNT = 3'd2,
		REG_KERNEL_SIZE  = 3'd3
	} cfg_reg_t;

	// controller to datapath
	typedef struct packed {
		logic wt_write;
		logic pix_take;
		logic lb_update;
		logic mac_start;
		logic tap_issue;
		logic next_filter;
		logic emit;
		logic adv_pos;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic win_full;
		logic tap_last;
		logic filt_last;
		logic pipe_busy;
		logic out_free;
	} sts_t;

endpackage

>>> design/cvmf_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_item_if
// Input channel: weight loads and image pixels.
// ----------------------------------------------------------------------------
interface cvmf_item_if import cvmf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [WIDX_W-1:0]         weight_index;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, opcode, weight_index, value, input ready);
	modport sink (input valid, opcode, weight_index, value, output ready);
endinterface

>>> design/cvmf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_result_if
// Output channel: one convolution sum per filter.
// ----------------------------------------------------------------------------
interface cvmf_result_if import cvmf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [FIDX_W-1:0]       filter_index;
	logic [ROW_W-1:0]        out_row;
	logic [COL_W-1:0]        out_col;
	logic signed [SUM_W-1:0] conv_sum;
	logic                    last_of_run;

	modport source (output valid, filter_index, out_row, out_col, conv_sum, last_of_run,
		input ready);
	modport sink (input valid, filter_index, out_row, out_col, conv_sum, last_of_run,
		output ready);
endinterface

>>> design/cvmf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface cvmf_cfg_if import cvmf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/cvmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_ctrl
// Sequencer: takes items, then walks taps and filters on the shared MAC.
// ----------------------------------------------------------------------------
module cvmf_ctrl import cvmf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_opcode,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LB,
		S_MAC,
		S_DRAIN,
		S_EMIT
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode_t'(in_opcode) == OP_PIXEL) begin
						cmd.pix_take = 1'b1;
						state_d      = S_LB;
					end else begin
						cmd.wt_write = 1'b1;
					end
				end
			end
			S_LB: begin
				cmd.lb_update = 1'b1;
				if (sts.win_full) begin
					cmd.mac_start = 1'b1;
					state_d       = S_MAC;
				end else begin
					cmd.adv_pos = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_MAC: begin
				cmd.tap_issue = 1'b1;
				if (sts.tap_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.filt_last) begin
						cmd.adv_pos = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.next_filter = 1'b1;
						state_d         = S_MAC;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> design/cvmf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvmf_dp
// Datapath: registers, weight store, line buffer, window, MAC pipe, result.
// ----------------------------------------------------------------------------
module cvmf_dp import cvmf_pkg::*; #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_FILTERS = 8,
	parameter int MAX_KERNEL  = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [WIDX_W-1:0]         in_weight_index,
	input  logic signed [VALUE_W-1:0] in_value,
	output logic                      res_valid,
	input  logic                      res_ready,
	output logic [FIDX_W-1:0]         res_filter_index,
	output logic [ROW_W-1:0]          res_out_row,
	output logic [COL_W-1:0]          res_out_col,
	output logic signed [SUM_W-1:0]   res_conv_sum,
	output logic                      res_last_of_run
);

	localparam int CW   = $clog2(MAX_COLS);
	localparam int CCW  = $clog2(MAX_COLS + 1);
	localparam int FW   = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
	localparam int FCW  = $clog2(MAX_FILTERS + 1);
	localparam int KW   = $clog2(MAX_KERNEL + 1);
	localparam int KIW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int TAPS = MAX_KERNEL * MAX_KERNEL;
	localparam int WD   = MAX_FILTERS * TAPS;
	localparam int WAW  = (WD > 1) ? $clog2(WD) : 1;
	localparam int SD   = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
	localparam int AW0  = 32 + $clog2(TAPS);
	localparam int AW   = (AW0 < SUM_W) ? SUM_W : AW0;

	// configuration and position
	logic [ROWS_W-1:0]  image_rows_q;
	logic [COLS_W-1:0]  image_cols_q;
	logic [FCNT_W-1:0]  filter_count_q;
	logic [KSIZE_W-1:0] kernel_size_q;
	logic [ROW_W-1:0]   row_q;
	logic [CW-1:0]      col_q;

	logic [ROWS_W-1:0]  rows_c;
	logic [CCW-1:0]     cols_c;
	logic [FCW-1:0]     nf_c;
	logic [KW-1:0]      k_c;

	// storage
	logic signed [VALUE_W-1:0] w_mem [WD];
	logic [SD*VALUE_W-1:0]     lb_mem [MAX_COLS];
	logic [SD*VALUE_W-1:0]     lb_rd_q;
	logic [SD*VALUE_W-1:0]     lb_wr;
	logic signed [VALUE_W-1:0] pix_q;
	logic signed [VALUE_W-1:0] win_q [MAX_KERNEL][MAX_KERNEL];
	logic signed [VALUE_W-1:0] col_vec [MAX_KERNEL];

	// tap walk
	logic [KIW-1:0] i_q, j_q;
	logic [FW-1:0]  f_q;
	logic [WAW-1:0] fbase_q, rbase_q;
	logic [WAW-1:0] w_addr;
	logic [KIW-1:0] slot, age;

	// MAC pipe
	logic                      v_s1, v_s2;
	logic signed [VALUE_W-1:0] w_s1, p_s1;
	logic signed [31:0]        prod_s2;
	logic signed [AW-1:0]      acc_q;
	logic signed [SUM_W-1:0]   acc_sat;

	always_comb begin
		if (image_rows_q == '0) rows_c = ROWS_W'(1);
		else if (32'(image_rows_q) > MAX_ROWS) rows_c = ROWS_W'(MAX_ROWS);
		else rows_c = image_rows_q;

		if (image_cols_q == '0) cols_c = CCW'(1);
		else if (32'(image_cols_q) > MAX_COLS) cols_c = CCW'(MAX_COLS);
		else cols_c = CCW'(image_cols_q);

		if (filter_count_q == '0) nf_c = FCW'(1);
		else if (32'(filter_count_q) > MAX_FILTERS) nf_c = FCW'(MAX_FILTERS);
		else nf_c = FCW'(filter_count_q);

		if (kernel_size_q == '0) k_c = KW'(1);
		else if (32'(kernel_size_q) > MAX_KERNEL) k_c = KW'(MAX_KERNEL);
		else k_c = KW'(kernel_size_q);
	end

	// new column stack: age 0 is the current pixel, age d from line buffer slot d-1
	always_comb begin
		col_vec[0] = pix_q;
		for (int d = 1; d < MAX_KERNEL; d++) begin
			col_vec[d] = lb_rd_q[(d-1)*VALUE_W +: VALUE_W];
		end
		lb_wr = lb_rd_q << VALUE_W;
		lb_wr[VALUE_W-1:0] = pix_q;
	end

	assign w_addr = WAW'(32'(rbase_q) + 32'(j_q));
	assign slot   = KIW'(MAX_KERNEL - 32'(k_c) + 32'(j_q));
	assign age    = KIW'(32'(k_c) - 1 - 32'(i_q));

	always_comb begin
		sts.win_full  = (32'(row_q) + 1 >= 32'(k_c)) && (32'(col_q) + 1 >= 32'(k_c));
		sts.tap_last  = (32'(i_q) + 1 == 32'(k_c)) && (32'(j_q) + 1 == 32'(k_c));
		sts.filt_last = (32'(f_q) + 1 == 32'(nf_c));
		sts.pipe_busy = v_s1 || v_s2;
		sts.out_free  = !res_valid || res_ready;
	end

	// clamp to the 36-bit range when the upper bits disagree
	always_comb begin
		if ((&acc_q[AW-1:SUM_W-1]) || !(|acc_q[AW-1:SUM_W-1])) begin
			acc_sat = acc_q[SUM_W-1:0];
		end else if (acc_q[AW-1]) begin
			acc_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			acc_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	// configuration and image position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_rows_q   <= ROWS_RESET;
			image_cols_q   <= COLS_RESET;
			filter_count_q <= FCNT_RESET;
			kernel_size_q  <= KSIZE_RESET;
			row_q          <= '0;
			col_q          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_ROWS:   image_rows_q   <= cfg_data;
				REG_IMAGE_COLS:   image_cols_q   <= cfg_data[COLS_W-1:0];
				REG_FILTER_COUNT: filter_count_q <= cfg_data[FCNT_W-1:0];
				REG_KERNEL_SIZE:  kernel_size_q  <= cfg_data[KSIZE_W-1:0];
				default: ;
			endcase
			if (cfg_index <= REG_KERNEL_SIZE) begin
				row_q <= '0;
				col_q <= '0;
			end
		end else if (cmd.adv_pos) begin
			if (32'(col_q) + 1 >= 32'(cols_c)) begin
				col_q <= '0;
				if (32'(row_q) + 1 >= 32'(rows_c)) row_q <= '0;
				else row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// weight store
	always_ff @(posedge clk) begin
		if (cmd.wt_write && 32'(in_weight_index) < WD) begin
			w_mem[WAW'(in_weight_index)] <= in_value;
		end
		w_s1 <= w_mem[w_addr];
	end

	// line buffer, pixel and window
	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			pix_q   <= in_value;
			lb_rd_q <= lb_mem[col_q];
		end
		if (cmd.lb_update) begin
			lb_mem[col_q] <= lb_wr;
			for (int x = 0; x + 1 < MAX_KERNEL; x++) begin
				win_q[x] <= win_q[x+1];
			end
			win_q[MAX_KERNEL-1] <= col_vec;
		end
	end

	// tap and filter counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			f_q     <= '0;
			fbase_q <= '0;
			rbase_q <= '0;
		end else if (cmd.mac_start) begin
			i_q     <= '0;
			j_q     <= '0;
			f_q     <= '0;
			fbase_q <= '0;
			rbase_q <= '0;
		end else if (cmd.next_filter) begin
			i_q     <= '0;
			j_q     <= '0;
			f_q     <= f_q + 1'b1;
			fbase_q <= WAW'(32'(fbase_q) + TAPS);
			rbase_q <= WAW'(32'(fbase_q) + TAPS);
		end else if (cmd.tap_issue) begin
			if (32'(j_q) + 1 == 32'(k_c)) begin
				j_q     <= '0;
				i_q     <= i_q + 1'b1;
				rbase_q <= WAW'(32'(rbase_q) + MAX_KERNEL);
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// MAC pipe: read, multiply, accumulate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.tap_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s1    <= win_q[slot][age];
		prod_s2 <= p_s1 * w_s1;
		if (cmd.mac_start || cmd.next_filter) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_filter_index <= FIDX_W'(f_q);
			res_out_row      <= ROW_W'(32'(row_q) - 32'(k_c) + 1);
			res_out_col      <= COL_W'(32'(col_q) - 32'(k_c) + 1);
			res_conv_sum     <= acc_sat;
			res_last_of_run  <= sts.filt_last;
		end
	end

endmodule

>>> design/conv2d_valid_multi_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_valid_multi_filter_top
// Valid-window 2D convolution of a raster image with several square filters.
// ----------------------------------------------------------------------------
// A weight load is taken in S_IDLE. A pixel passes S_IDLE and S_LB; when it
// completes a window (k kernel size, nf filter count), each of the nf filters
// runs its k*k taps through S_MAC, S_DRAIN and S_EMIT in turn, on one shared
// multiply-accumulate, one tap per cycle. New items wait until S_IDLE.
// Reset clears position, registers (28x28, 8 filters, k=3) and result valid;
// weights are undefined until loaded, no clearing pass is needed.
module conv2d_valid_multi_filter_top import cvmf_pkg::*; #(
	parameter int MAX_COLS    = 64,
	parameter int MAX_FILTERS = 8,
	parameter int MAX_KERNEL  = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	cvmf_item_if.sink     item,
	cvmf_result_if.source result,
	cvmf_cfg_if.sink      cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	cvmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_opcode (item.opcode),
		.in_ready  (item.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cvmf_dp #(
		.MAX_COLS    (MAX_COLS),
		.MAX_FILTERS (MAX_FILTERS),
		.MAX_KERNEL  (MAX_KERNEL)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.in_weight_index  (item.weight_index),
		.in_value         (item.value),
		.res_valid        (result.valid),
		.res_ready        (result.ready),
		.res_filter_index (result.filter_index),
		.res_out_row      (result.out_row),
		.res_out_col      (result.out_col),
		.res_conv_sum     (result.conv_sum),
		.res_last_of_run  (result.last_of_run)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded over a pending item");

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !sts.pipe_busy)
		else $error("input taken while MAC pipe busy");

	a_issue_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.tap_issue && (cmd.emit || cmd.pix_take)))
		else $error("tap issued alongside emit or pixel take");

endmodule

>>> dv/tb_conv2d_valid_multi_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv2d_valid_multi_filter_top
// Self-checking bench for the multi-filter valid-window convolution. A
// behavioral convolution predictor tracks weights, line buffer and position,
// and a scoreboard compares every sum with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_conv2d_valid_multi_filter_top;
	import cvmf_pkg::*;

	localparam int MCOLS = 64;
	localparam int MFILT = 8;
	localparam int MKER  = 5;
	localparam int TAPS  = MKER * MKER;
	localparam int DEPTH = MFILT * TAPS;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [FIDX_W-1:0]       filt;
		logic [ROW_W-1:0]        row;
		logic [COL_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
		logic                    last;
	} conv_sum_t;

	class conv_scoreboard;
		logic [ROWS_W-1:0]  rows_reg;
		logic [COLS_W-1:0]  cols_reg;
		logic [FCNT_W-1:0]  fcnt_reg;
		logic [KSIZE_W-1:0] ksize_reg;
		logic signed [VALUE_W-1:0] weights[DEPTH];
		logic signed [VALUE_W-1:0] line_buf[MKER-1][MCOLS];
		logic signed [VALUE_W-1:0] window[MKER][MKER];
		int pos_row, pos_col;
		conv_sum_t pending_sums[$];
		int mismatches;

		function new();
			rows_reg = ROWS_RESET;
			cols_reg = COLS_RESET;
			fcnt_reg = FCNT_RESET;
			ksize_reg = KSIZE_RESET;
			foreach (weights[i]) weights[i] = '0;
			foreach (line_buf[i, j]) line_buf[i][j] = '0;
			foreach (window[i, j]) window[i][j] = '0;
			pos_row = 0;
			pos_col = 0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_ROWS:   rows_reg = data[ROWS_W-1:0];
				REG_IMAGE_COLS:   cols_reg = data[COLS_W-1:0];
				REG_FILTER_COUNT: fcnt_reg = data[FCNT_W-1:0];
				REG_KERNEL_SIZE:  ksize_reg = data[KSIZE_W-1:0];
				default: return;
			endcase
			pos_row = 0;
			pos_col = 0;
		endfunction

		static function int clip(int v, int lo, int hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void note_item(opcode_t op, logic [WIDX_W-1:0] widx,
				logic signed [VALUE_W-1:0] val);
			int rows, cols, nf, k;
			longint acc;
			conv_sum_t s;
			rows = clip(rows_reg, 1, MAX_ROWS);
			cols = clip(cols_reg, 1, MCOLS);
			nf = clip(fcnt_reg, 1, MFILT);
			k = clip(ksize_reg, 1, MKER);
			if (op == OP_WEIGHT) begin
				if (widx < DEPTH)
					weights[widx] = val;
				return;
			end
			// shift window left, newest column gets pixel over its stack
			for (int x = 0; x < MKER - 1; x++)
				window[x] = window[x + 1];
			window[MKER-1][0] = val;
			for (int d = 1; d < MKER; d++)
				window[MKER-1][d] = line_buf[d-1][pos_col];
			for (int d = MKER - 2; d > 0; d--)
				line_buf[d][pos_col] = line_buf[d-1][pos_col];
			line_buf[0][pos_col] = val;
			if (pos_row + 1 >= k && pos_col + 1 >= k) begin
				for (int f = 0; f < nf; f++) begin
					acc = 0;
					for (int i = 0; i < k; i++)
						for (int j = 0; j < k; j++)
							acc += longint'(window[MKER-k+j][k-1-i])
								* longint'(weights[f*TAPS + i*MKER + j]);
					if (acc > 64'sd34359738367) acc = 64'sd34359738367;
					if (acc < -64'sd34359738368) acc = -64'sd34359738368;
					s.filt = FIDX_W'(f);
					s.row = ROW_W'(pos_row + 1 - k);
					s.col = COL_W'(pos_col + 1 - k);
					s.sum = acc[SUM_W-1:0];
					s.last = (f + 1 == nf);
					pending_sums.push_back(s);
				end
			end
			pos_col++;
			if (pos_col >= cols) begin
				pos_col = 0;
				pos_row++;
				if (pos_row >= rows) pos_row = 0;
			end
		endfunction

		function void check_sum(conv_sum_t got);
			conv_sum_t exp_s;
			if (pending_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected sum %p", got);
				return;
			end
			exp_s = pending_sums.pop_front();
			if (got !== exp_s) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR: sum mismatch expected f%0d r%0d c%0d %0d l%0d",
						exp_s.filt, exp_s.row, exp_s.col, exp_s.sum, exp_s.last);
					$display("       got f%0d r%0d c%0d %0d l%0d",
						got.filt, got.row, got.col, got.sum, got.last);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int src_idle_pct, snk_idle_pct;
	int quiet_cycles = 0;
	conv_scoreboard sb;

	cvmf_item_if   item();
	cvmf_result_if result();
	cvmf_cfg_if    cfg();

	conv2d_valid_multi_filter_top i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item.sink),
		.result(result.source),
		.cfg   (cfg.sink)
	);

	always #5 clk = ~clk;

	initial begin
		item.valid = 1'b0;
		item.opcode = OP_WEIGHT;
		item.weight_index = '0;
		item.value = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		result.ready = 1'b0;
	end

	// receiver with random stall; check on accepted sums
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				sb.check_sum({result.filter_index, result.out_row, result.out_col,
					result.conv_sum, result.last_of_run});
			result.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (result.valid && result.ready)
				|| (cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > WATCHDOG) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// valid stays high after an accept so items can follow back to back;
	// idle cycles and drain drop it
	task automatic send_item(opcode_t op, logic [WIDX_W-1:0] widx,
			logic signed [VALUE_W-1:0] val);
		cfg.valid <= 1'b0;
		while ($urandom_range(99) < src_idle_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.opcode <= op;
		item.weight_index <= widx;
		item.value <= val;
		do @(posedge clk); while (!item.ready);
		sb.note_item(op, widx, val);
	endtask

	task automatic drain();
		item.valid <= 1'b0;
		while (sb.pending_sums.size() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	// valid is dropped by the next send_item
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, data);
	endtask

	task automatic setup(int rows, int cols, int nf, int k);
		drain();
		write_reg(REG_IMAGE_ROWS, CFG_DATA_W'(rows));
		write_reg(REG_IMAGE_COLS, CFG_DATA_W'(cols));
		write_reg(REG_FILTER_COUNT, CFG_DATA_W'(nf));
		write_reg(REG_KERNEL_SIZE, CFG_DATA_W'(k));
	endtask

	task automatic load_weights(bit extreme);
		logic signed [VALUE_W-1:0] w;
		for (int i = 0; i < DEPTH; i++) begin
			w = extreme ? ((i % 2) ? 16'sh8000 : 16'sh7fff) : VALUE_W'($urandom);
			send_item(OP_WEIGHT, WIDX_W'(i), w);
		end
	endtask

	task automatic update_weights(int n);
		for (int i = 0; i < n; i++)
			send_item(OP_WEIGHT, WIDX_W'($urandom_range(DEPTH - 1)),
				VALUE_W'($urandom));
	endtask

	task automatic send_pixels(int n, bit extreme);
		logic signed [VALUE_W-1:0] p;
		for (int i = 0; i < n; i++) begin
			if (extreme)
				p = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
			else
				p = VALUE_W'($urandom);
			send_item(OP_PIXEL, WIDX_W'($urandom), p);
		end
	endtask

	initial begin
		sb = new();
		src_idle_pct = 25;
		snk_idle_pct = 45;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme weights and pixels, ignored weight index, bad reg index
		load_weights(1'b1);
		send_item(OP_WEIGHT, 8'd200, 16'sh1234);
		send_item(OP_WEIGHT, 8'd255, 16'sh7fff);
		setup(4, 4, 8, 3);
		write_reg(cfg_reg_t'(3'd7), 11'h7ff);
		send_pixels(16, 1'b1);
		// kernel larger than image: no sums
		setup(3, 3, 1, 5);
		send_pixels(9, 1'b0);

		// random phases; settings cycle through extremes
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				src_idle_pct = 45;
				snk_idle_pct = 25;
			end else if (ph == 4) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			drain();
			update_weights(3);
			case (ph)
				0: setup(5, 5, 8, 5);
				1: setup(1, 64, 1, 1);
				2: setup(2047, 5, 15, 7);   // out-of-range values clamp
				3: setup(3, 127, 0, 0);
				4: setup($urandom_range(1, 8), $urandom_range(1, 12),
					$urandom_range(1, 8), $urandom_range(1, 5));
				default: setup(1024, 6, 3, 2);
			endcase
			send_pixels(30, ph == 2);
		end

		drain();
		if (sb.mismatches == 0 && sb.pending_sums.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
